[design/led_panel_framebuffer_scanner_top_macros.svh]
// Assertion macros for the frame store scanner.
`ifndef LED_PANEL_FRAMEBUFFER_SCANNER_TOP_MACROS_SVH
`define LED_PANEL_FRAMEBUFFER_SCANNER_TOP_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define LPFS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, clocked on clk, off during reset.
`define LPFS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[design/lpfs_pkg.sv]
`default_nettype none
package lpfs_pkg;

	localparam int MAX_WIDTH_DEF = 64;
	localparam int HALF_ROWS_DEF = 16;
	localparam int QDEPTH = 2;

	localparam logic [6:0] LINE_WIDTH_RESET = 7'd64;
	localparam logic [7:0] INVERT_RESET = 8'h00;
	localparam logic [7:0] ENABLE_RESET = 8'hFF;
	localparam logic [7:0] PIXEL_MSB = 8'h80;
	localparam logic [2:0] BIT_MSB = 3'd7;

	localparam logic [1:0] ACT_WRITE = 2'd0;
	localparam logic [1:0] ACT_CLEAR = 2'd1;
	localparam logic [1:0] ACT_SCAN = 2'd2;

	localparam logic KIND_SHIFT = 1'b0;
	localparam logic KIND_LATCH = 1'b1;

	localparam logic [1:0] REG_LINE_WIDTH = 2'd0;
	localparam logic [1:0] REG_INVERT = 2'd1;
	localparam logic [1:0] REG_ENABLE = 2'd2;

	typedef enum logic [1:0] {
		OP_WRITE,
		OP_CLEAR,
		OP_SHIFT,
		OP_LATCH
	} op_t;

	typedef struct packed {
		op_t op;
		logic [2:0] bitpos;
		logic value;
		logic [3:0] row;
	} entry_ctrl_t;

endpackage
`default_nettype wire

[design/lpfs_front.sv]
`default_nettype none
module lpfs_front #(
	parameter int MAX_WIDTH = lpfs_pkg::MAX_WIDTH_DEF,
	parameter int HALF_ROWS = lpfs_pkg::HALF_ROWS_DEF,
	parameter int AW = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic [5:0] pos_x,
	input wire logic [4:0] pos_y,
	input wire logic pixel_value,
	input wire logic [6:0] line_width,
	input wire logic q_full,
	output logic push,
	output lpfs_pkg::entry_ctrl_t push_ctrl,
	output logic [AW-1:0] push_addr_a,
	output logic [AW-1:0] push_addr_b
);

	localparam int BPL_MAX = MAX_WIDTH / 8;
	localparam int BPLW = $clog2(BPL_MAX + 1);
	localparam int COLW = BPLW + 3;
	localparam int RW = $clog2(HALF_ROWS);

	logic [3:0] lw_bytes;
	logic [BPLW-1:0] bpl;
	logic [COLW-1:0] cols;
	logic [RW-1:0] scan_row_q;
	logic [COLW-1:0] scan_col_q;
	logic accept;
	logic keep;
	logic col_open;
	logic [AW-1:0] wr_addr;
	logic [AW-1:0] up_addr;
	logic [AW-1:0] lo_addr;

	assign lw_bytes = line_width[6:3];

	always_comb begin
		if (32'(lw_bytes) > 32'(BPL_MAX)) begin
			bpl = BPLW'(BPL_MAX);
		end else begin
			bpl = BPLW'(lw_bytes);
		end
	end

	assign cols = {bpl, 3'b000};
	assign col_open = scan_col_q < cols;
	assign in_ready = !q_full;
	assign accept = in_valid && in_ready;

	assign wr_addr = AW'(32'(pos_y) * 32'(bpl) + 32'(pos_x[5:3]));
	assign up_addr = AW'(32'(scan_row_q) * 32'(bpl) + 32'(scan_col_q[COLW-1:3]));
	assign lo_addr = AW'((32'(scan_row_q) + 32'(HALF_ROWS)) * 32'(bpl)
		+ 32'(scan_col_q[COLW-1:3]));

	always_comb begin
		keep = 1'b0;
		push_ctrl.op = lpfs_pkg::OP_WRITE;
		push_ctrl.bitpos = pos_x[2:0];
		push_ctrl.value = pixel_value;
		push_ctrl.row = 4'(scan_row_q);
		push_addr_a = wr_addr;
		push_addr_b = lo_addr;
		case (action)
			lpfs_pkg::ACT_WRITE: begin
				keep = (32'(pos_x) < 32'(cols)) && (32'(pos_y) < 32'(2 * HALF_ROWS));
			end
			lpfs_pkg::ACT_CLEAR: begin
				keep = 1'b1;
				push_ctrl.op = lpfs_pkg::OP_CLEAR;
			end
			lpfs_pkg::ACT_SCAN: begin
				keep = 1'b1;
				push_ctrl.bitpos = scan_col_q[2:0];
				push_addr_a = up_addr;
				if (col_open) begin
					push_ctrl.op = lpfs_pkg::OP_SHIFT;
				end else begin
					push_ctrl.op = lpfs_pkg::OP_LATCH;
				end
			end
			default: begin
				keep = 1'b0;
			end
		endcase
	end

	assign push = accept && keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_row_q <= '0;
			scan_col_q <= '0;
		end else if (accept && action == lpfs_pkg::ACT_SCAN) begin
			if (col_open) begin
				scan_col_q <= scan_col_q + 1'b1;
			end else begin
				scan_col_q <= '0;
				if (scan_row_q == RW'(HALF_ROWS - 1)) begin
					scan_row_q <= '0;
				end else begin
					scan_row_q <= scan_row_q + 1'b1;
				end
			end
		end
	end

endmodule
`default_nettype wire

[design/lpfs_queue.sv]
`default_nettype none
module lpfs_queue #(
	parameter int AW = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire lpfs_pkg::entry_ctrl_t push_ctrl,
	input wire logic [AW-1:0] push_addr_a,
	input wire logic [AW-1:0] push_addr_b,
	input wire logic pop,
	output logic full,
	output logic empty,
	output lpfs_pkg::entry_ctrl_t head_ctrl,
	output logic [AW-1:0] head_addr_a,
	output logic [AW-1:0] head_addr_b
);

	localparam int PW = $clog2(lpfs_pkg::QDEPTH);
	localparam int CW = $clog2(lpfs_pkg::QDEPTH + 1);

	lpfs_pkg::entry_ctrl_t ctrl_q [lpfs_pkg::QDEPTH];
	logic [AW-1:0] addr_a_q [lpfs_pkg::QDEPTH];
	logic [AW-1:0] addr_b_q [lpfs_pkg::QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full = count_q == CW'(lpfs_pkg::QDEPTH);
	assign empty = count_q == '0;
	assign head_ctrl = ctrl_q[rd_ptr_q];
	assign head_addr_a = addr_a_q[rd_ptr_q];
	assign head_addr_b = addr_b_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_ptr_q] <= push_ctrl;
			addr_a_q[wr_ptr_q] <= push_addr_a;
			addr_b_q[wr_ptr_q] <= push_addr_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				if (wr_ptr_q == PW'(lpfs_pkg::QDEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
			if (pop) begin
				if (rd_ptr_q == PW'(lpfs_pkg::QDEPTH - 1)) begin
					rd_ptr_q <= '0;
				end else begin
					rd_ptr_q <= rd_ptr_q + 1'b1;
				end
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[design/lpfs_back.sv]
`default_nettype none
module lpfs_back #(
	parameter int STORE_BYTES = 256,
	parameter int AW = 8
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic head_valid,
	input wire lpfs_pkg::entry_ctrl_t head_ctrl,
	input wire logic [AW-1:0] head_addr_a,
	input wire logic [AW-1:0] head_addr_b,
	output logic pop,
	input wire logic [7:0] invert_mask,
	input wire logic [7:0] column_enable,
	output logic out_valid,
	input wire logic out_ready,
	output logic kind,
	output logic upper_bit,
	output logic lower_bit,
	output logic [3:0] row_address
);

	logic [7:0] mem_q [STORE_BYTES];
	logic [STORE_BYTES-1:0] valid_q;
	logic [7:0] rd_a_s1;
	logic [7:0] rd_b_s1;
	logic vld_a_s1;
	logic vld_b_s1;
	logic [2:0] bitpos_s1;
	logic [3:0] row_s1;
	logic kind_s1;
	logic s1_valid_q;
	logic out_valid_q;
	logic kind_q;
	logic upper_q;
	logic lower_q;
	logic [3:0] row_q;
	logic is_scan;
	logic out_free;
	logic s1_adv;
	logic s1_free;
	logic pop_write;
	logic pop_scan;
	logic [2:0] wr_idx;
	logic [2:0] rd_idx;
	logic up_bit;
	logic lo_bit;

	assign is_scan = head_ctrl.op inside {lpfs_pkg::OP_SHIFT, lpfs_pkg::OP_LATCH};
	assign out_free = !out_valid_q || out_ready;
	assign s1_adv = s1_valid_q && out_free;
	assign s1_free = !s1_valid_q || s1_adv;
	assign pop = head_valid && (!is_scan || s1_free);
	assign pop_write = pop && head_ctrl.op == lpfs_pkg::OP_WRITE;
	assign pop_scan = pop && is_scan;
	assign wr_idx = lpfs_pkg::BIT_MSB - head_ctrl.bitpos;
	assign rd_idx = lpfs_pkg::BIT_MSB - bitpos_s1;

	// Store bytes not yet written since reset or clear read as zero
	always_ff @(posedge clk) begin
		if (pop_write) begin
			if (valid_q[head_addr_a]) begin
				mem_q[head_addr_a][wr_idx] <= head_ctrl.value;
			end else begin
				mem_q[head_addr_a] <= head_ctrl.value ?
					(lpfs_pkg::PIXEL_MSB >> head_ctrl.bitpos) : 8'h00;
			end
		end
		if (pop_scan) begin
			rd_a_s1 <= mem_q[head_addr_a];
			rd_b_s1 <= mem_q[head_addr_b];
			vld_a_s1 <= valid_q[head_addr_a];
			vld_b_s1 <= valid_q[head_addr_b];
			bitpos_s1 <= head_ctrl.bitpos;
			row_s1 <= head_ctrl.row;
			kind_s1 <= (head_ctrl.op == lpfs_pkg::OP_LATCH) ?
				lpfs_pkg::KIND_LATCH : lpfs_pkg::KIND_SHIFT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (pop && head_ctrl.op == lpfs_pkg::OP_CLEAR) begin
			valid_q <= '0;
		end else if (pop_write) begin
			valid_q[head_addr_a] <= 1'b1;
		end
	end

	assign up_bit = ((vld_a_s1 & rd_a_s1[rd_idx]) ^ invert_mask[rd_idx]) & column_enable[rd_idx];
	assign lo_bit = ((vld_b_s1 & rd_b_s1[rd_idx]) ^ invert_mask[rd_idx]) & column_enable[rd_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop_scan) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			kind_q <= kind_s1;
			if (kind_s1 == lpfs_pkg::KIND_LATCH) begin
				upper_q <= 1'b0;
				lower_q <= 1'b0;
				row_q <= row_s1;
			end else begin
				upper_q <= up_bit;
				lower_q <= lo_bit;
				row_q <= 4'd0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign kind = kind_q;
	assign upper_bit = upper_q;
	assign lower_bit = lower_q;
	assign row_address = row_q;

endmodule
`default_nettype wire

[design/led_panel_framebuffer_scanner_top.sv]
// A scan tick accepted passes the queue, the store read stage and the output register.
// One transaction per cycle on any action mix, clear included, if out_ready is high.
// The store is a byte memory with one registered two-port read; one bit per byte marks
// bytes written since the last clear, so clear and reset take effect at once.
// Reset: empty queue and pipeline, scan at row 0 column 0, registers at defaults.
`default_nettype none
`include "led_panel_framebuffer_scanner_top_macros.svh"
module led_panel_framebuffer_scanner_top #(
	parameter int MAX_WIDTH = lpfs_pkg::MAX_WIDTH_DEF,
	parameter int HALF_ROWS = lpfs_pkg::HALF_ROWS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [3:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] action,
	input wire logic [5:0] pos_x,
	input wire logic [4:0] pos_y,
	input wire logic pixel_value,
	output logic out_valid,
	input wire logic out_ready,
	output logic kind,
	output logic upper_bit,
	output logic lower_bit,
	output logic [3:0] row_address
);

	localparam int STORE_BYTES = (MAX_WIDTH / 8) * 2 * HALF_ROWS;
	localparam int AW = $clog2(STORE_BYTES);

	logic [6:0] line_width_q;
	logic [7:0] invert_q;
	logic [7:0] enable_q;
	logic cfg_wr;
	logic q_push;
	logic q_pop;
	logic q_full;
	logic q_empty;
	lpfs_pkg::entry_ctrl_t push_ctrl;
	lpfs_pkg::entry_ctrl_t head_ctrl;
	logic [AW-1:0] push_addr_a;
	logic [AW-1:0] push_addr_b;
	logic [AW-1:0] head_addr_a;
	logic [AW-1:0] head_addr_b;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= lpfs_pkg::LINE_WIDTH_RESET;
			invert_q <= lpfs_pkg::INVERT_RESET;
			enable_q <= lpfs_pkg::ENABLE_RESET;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				lpfs_pkg::REG_LINE_WIDTH: line_width_q <= pwdata[6:0];
				lpfs_pkg::REG_INVERT: invert_q <= pwdata[7:0];
				lpfs_pkg::REG_ENABLE: enable_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			lpfs_pkg::REG_LINE_WIDTH: prdata = {25'd0, line_width_q};
			lpfs_pkg::REG_INVERT: prdata = {24'd0, invert_q};
			lpfs_pkg::REG_ENABLE: prdata = {24'd0, enable_q};
			default: prdata = 32'd0;
		endcase
	end

	lpfs_front #(
		.MAX_WIDTH(MAX_WIDTH),
		.HALF_ROWS(HALF_ROWS),
		.AW(AW)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.pos_x(pos_x),
		.pos_y(pos_y),
		.pixel_value(pixel_value),
		.line_width(line_width_q),
		.q_full(q_full),
		.push(q_push),
		.push_ctrl(push_ctrl),
		.push_addr_a(push_addr_a),
		.push_addr_b(push_addr_b)
	);

	lpfs_queue #(
		.AW(AW)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(q_push),
		.push_ctrl(push_ctrl),
		.push_addr_a(push_addr_a),
		.push_addr_b(push_addr_b),
		.pop(q_pop),
		.full(q_full),
		.empty(q_empty),
		.head_ctrl(head_ctrl),
		.head_addr_a(head_addr_a),
		.head_addr_b(head_addr_b)
	);

	lpfs_back #(
		.STORE_BYTES(STORE_BYTES),
		.AW(AW)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(!q_empty),
		.head_ctrl(head_ctrl),
		.head_addr_a(head_addr_a),
		.head_addr_b(head_addr_b),
		.pop(q_pop),
		.invert_mask(invert_q),
		.column_enable(enable_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.upper_bit(upper_bit),
		.lower_bit(lower_bit),
		.row_address(row_address)
	);

	`LPFS_ASSERT_NOW(a_push_room, q_push, !q_full)
	`LPFS_ASSERT_NOW(a_pop_has_entry, q_pop, !q_empty)
	`LPFS_ASSERT_NEXT(a_push_lands, q_push && q_empty, !q_empty)
	`LPFS_ASSERT_NOW(a_latch_no_data, out_valid && kind == lpfs_pkg::KIND_LATCH, !upper_bit && !lower_bit)

endmodule
`default_nettype wire
